[rtl/overlapping_frame_ring_buffer_assert.svh]
// Assertion macros used by the back end of the overlapped frame store RTL.
`ifndef OVERLAPPING_FRAME_RING_BUFFER_ASSERT_SVH
`define OVERLAPPING_FRAME_RING_BUFFER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define OFRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Check that a trigger is followed in the next cycle by a condition.
`define OFRB_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);
`else
`define OFRB_ASSERT(label, prop, msg)
`define OFRB_ASSERT_NEXT(label, trig, cond, msg)
`endif

`endif

[rtl/ofrb_pkg.sv]
// Shared constants, types and helper functions of the overlapped frame store.
package ofrb_pkg;

  localparam int unsigned MAX_FRAME   = 64;
  localparam int unsigned STORE_DEPTH = MAX_FRAME * 8;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned FILL_W      = $clog2(STORE_DEPTH + 1);
  localparam int unsigned FRAME_CAP   = (MAX_FRAME < STORE_DEPTH) ? MAX_FRAME : STORE_DEPTH;
  localparam int unsigned FRAME_W     = $clog2(FRAME_CAP + 1);
  localparam int unsigned SUM_W       = ((ADDR_W > FRAME_W) ? ADDR_W : FRAME_W) + 1;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned ZCOUNT_W = 10;
  localparam int unsigned CFG_W    = 7;

  // Configuration register indexes and reset values
  localparam int unsigned        CFG_IDX_W        = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOP_LENGTH   = 1'd1;
  localparam logic [CFG_W-1:0]   FRAME_LENGTH_RST = 7'd64;
  localparam logic [CFG_W-1:0]   HOP_LENGTH_RST   = 7'd32;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ZEROS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result buffer in the back end
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OPTR_W    = $clog2(OUT_DEPTH);
  localparam int unsigned OCNT_W    = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_ZEROS,
    OP_READ
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ZERO,
    ST_READ
  } back_state_e;

  typedef struct packed {
    op_e                 op;
    logic [SAMPLE_W-1:0] sample;
    logic [ZCOUNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] hop;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                ok;
    logic                last;
  } res_t;

  // Bound the frame length to one and to the largest frame the store allows
  function automatic logic [FRAME_W-1:0] clamp_frame(input logic [CFG_W-1:0] raw);
    logic [FRAME_W-1:0] f;
    if (raw == '0) begin
      f = FRAME_W'(1);
    end else if (raw > FRAME_CAP) begin
      f = FRAME_W'(FRAME_CAP);
    end else begin
      f = FRAME_W'(raw);
    end
    return f;
  endfunction

  // Bound the hop to one and to the effective frame length
  function automatic logic [FRAME_W-1:0] clamp_hop(input logic [CFG_W-1:0]   raw,
                                                   input logic [FRAME_W-1:0] frame);
    logic [FRAME_W-1:0] h;
    if (raw == '0) begin
      h = FRAME_W'(1);
    end else if (raw > frame) begin
      h = frame;
    end else begin
      h = FRAME_W'(raw);
    end
    return h;
  endfunction

  // Advance a store position, wrapping at the store depth
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0]  pos,
                                                 input logic [FRAME_W-1:0] inc);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(pos) + SUM_W'(inc);
    if (sum >= SUM_W'(STORE_DEPTH)) begin
      sum = sum - SUM_W'(STORE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

[rtl/ofrb_if.sv]
// Valid/ready channel interfaces for commands in and frame samples out.
interface ofrb_in_if;
  import ofrb_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [SAMPLE_W-1:0] sample;
  logic [ZCOUNT_W-1:0] zero_count;

  modport source (output valid, output command, output sample, output zero_count,
                  input ready);
  modport sink   (input valid, input command, input sample, input zero_count,
                  output ready);
endinterface

interface ofrb_out_if;
  import ofrb_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] frame_sample;
  logic                frame_ok;
  logic                last;

  modport source (output valid, output frame_sample, output frame_ok, output last,
                  input ready);
  modport sink   (input valid, input frame_sample, input frame_ok, input last,
                  output ready);
endinterface

[rtl/ofrb_front.sv]
// Front end: configuration registers, command acceptance and classification.
module ofrb_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ofrb_in_if.sink                         in_if,
  input  logic                            cfg_we_i,
  input  logic [ofrb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ofrb_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output ofrb_pkg::cmd_t                  q_cmd_o,
  output ofrb_pkg::cfg_t                  cfg_o
);
  import ofrb_pkg::*;

  logic [CFG_W-1:0]   frame_len_q;
  logic [CFG_W-1:0]   hop_len_q;
  logic [FRAME_W-1:0] frame_eff;
  logic               accept;
  logic               keep;
  op_e                op;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= FRAME_LENGTH_RST;
      hop_len_q   <= HOP_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_LENGTH: frame_len_q <= cfg_data_i;
        CFG_HOP_LENGTH:   hop_len_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Bound frame and hop to their working ranges
  assign frame_eff   = clamp_frame(frame_len_q);
  assign cfg_o.frame = frame_eff;
  assign cfg_o.hop   = clamp_hop(hop_len_q, frame_eff);

  // Accept whenever the queue has room
  assign in_if.ready = !q_full_i;
  assign accept      = in_if.valid && in_if.ready;

  // Classify the command; drop unknown codes
  always_comb begin
    op   = OP_WRITE;
    keep = 1'b1;
    unique case (in_if.command)
      CMD_WRITE: op = OP_WRITE;
      CMD_ZEROS: op = OP_ZEROS;
      CMD_READ:  op = OP_READ;
      default:   keep = 1'b0;
    endcase
  end

  assign q_push_o       = accept && keep;
  assign q_cmd_o.op     = op;
  assign q_cmd_o.sample = in_if.sample;
  assign q_cmd_o.count  = in_if.zero_count;

endmodule

[rtl/ofrb_queue.sv]
// Short command queue that decouples the front end from the back end.
module ofrb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ofrb_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ofrb_pkg::cmd_t cmd_o
);
  import ofrb_pkg::*;

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

[rtl/ofrb_back.sv]
// Back end: sample store, position tracking, frame read-out and result buffer.
`include "overlapping_frame_ring_buffer_assert.svh"

module ofrb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ofrb_pkg::cmd_t q_cmd_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  input  ofrb_pkg::cfg_t cfg_i,
  ofrb_out_if.source     out_if
);
  import ofrb_pkg::*;

  // Sample store
  logic [SAMPLE_W-1:0] mem_q [STORE_DEPTH];
  logic                mem_we;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [SAMPLE_W-1:0] rdata_q;

  // Sequencer state
  back_state_e         state_q, state_d;
  logic [ZCOUNT_W-1:0] cnt_q, cnt_d;
  logic [FRAME_W-1:0]  idx_q, idx_d;
  logic                ok_q, ok_d;
  logic [ADDR_W-1:0]   wr_pos_q, wr_pos_d;
  logic [ADDR_W-1:0]   rd_pos_q, rd_pos_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [FILL_W-1:0]   fill_inc;
  logic [FRAME_W-1:0]  frame_m1;
  logic                issue;
  logic                issue_last;
  logic                credit;

  // Read stage
  logic s1_valid_q;
  logic s1_ok_q;
  logic s1_last_q;

  // Result buffer
  res_t              obuf_q [OUT_DEPTH];
  logic [OPTR_W-1:0] owr_q;
  logic [OPTR_W-1:0] ord_q;
  logic [OCNT_W-1:0] ocnt_q;
  logic              o_push;
  logic              o_pop;
  res_t              o_entry;

  assign fill_inc = (fill_q == FILL_W'(STORE_DEPTH)) ? fill_q : fill_q + FILL_W'(1);
  assign frame_m1 = cfg_i.frame - FRAME_W'(1);
  assign credit   = (OCNT_W'(ocnt_q) + OCNT_W'(s1_valid_q)) < OCNT_W'(OUT_DEPTH);

  // Sequence writes, zero runs and frame reads
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    ok_d       = ok_q;
    wr_pos_d   = wr_pos_q;
    rd_pos_d   = rd_pos_q;
    fill_d     = fill_q;
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    mem_wdata  = '0;
    issue      = 1'b0;
    issue_last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          unique case (q_cmd_i.op)
            OP_WRITE: begin
              mem_we    = 1'b1;
              mem_wdata = q_cmd_i.sample;
              wr_pos_d  = wrap_add(wr_pos_q, FRAME_W'(1));
              fill_d    = fill_inc;
            end
            OP_ZEROS: begin
              if (q_cmd_i.count != '0) begin
                cnt_d   = q_cmd_i.count;
                state_d = ST_ZERO;
              end
            end
            OP_READ: begin
              ok_d    = (fill_q >= FILL_W'(cfg_i.frame));
              idx_d   = '0;
              state_d = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_ZERO: begin
        mem_we   = 1'b1;
        wr_pos_d = wrap_add(wr_pos_q, FRAME_W'(1));
        fill_d   = fill_inc;
        cnt_d    = cnt_q - ZCOUNT_W'(1);
        if (cnt_q == ZCOUNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (credit) begin
          issue      = 1'b1;
          issue_last = !ok_q || (idx_q == frame_m1);
          idx_d      = idx_q + FRAME_W'(1);
          if (issue_last) begin
            state_d = ST_IDLE;
            if (ok_q) begin
              rd_pos_d = wrap_add(rd_pos_q, cfg_i.hop);
              fill_d   = fill_q - FILL_W'(cfg_i.hop);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign mem_re    = issue && ok_q;
  assign mem_raddr = wrap_add(rd_pos_q, idx_q);

  // Hold sequencer state and positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      ok_q     <= 1'b0;
      wr_pos_q <= '0;
      rd_pos_q <= '0;
      fill_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      ok_q     <= ok_d;
      wr_pos_q <= wr_pos_d;
      rd_pos_q <= rd_pos_d;
      fill_q   <= fill_d;
    end
  end

  // Write and read the sample store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_pos_q] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Track reads in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_ok_q   <= ok_q;
      s1_last_q <= issue_last;
    end
  end

  // Queue results for the output channel
  assign o_push         = s1_valid_q;
  assign o_pop          = out_if.valid && out_if.ready;
  assign o_entry.sample = s1_ok_q ? rdata_q : '0;
  assign o_entry.ok     = s1_ok_q;
  assign o_entry.last   = s1_last_q;

  always_ff @(posedge clk_i) begin
    if (o_push) begin
      obuf_q[owr_q] <= o_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (o_push) begin
        owr_q <= owr_q + OPTR_W'(1);
      end
      if (o_pop) begin
        ord_q <= ord_q + OPTR_W'(1);
      end
      if (o_push && !o_pop) begin
        ocnt_q <= ocnt_q + OCNT_W'(1);
      end else if (o_pop && !o_push) begin
        ocnt_q <= ocnt_q - OCNT_W'(1);
      end
    end
  end

  assign out_if.valid        = (ocnt_q != '0);
  assign out_if.frame_sample = obuf_q[ord_q].sample;
  assign out_if.frame_ok     = obuf_q[ord_q].ok;
  assign out_if.last         = obuf_q[ord_q].last;

  // Checks on store accounting and result flow
  `OFRB_ASSERT(a_fill_bound, fill_q <= FILL_W'(STORE_DEPTH), "fill above depth")
  `OFRB_ASSERT(a_obuf_room, o_push |-> (ocnt_q != OCNT_W'(OUT_DEPTH)) || o_pop, "obuf overflow")
  `OFRB_ASSERT(a_read_has_data, (state_q == ST_READ) && ok_q |-> fill_q >= FILL_W'(cfg_i.frame), "no data")
  `OFRB_ASSERT(a_no_rw_clash, !(mem_we && mem_re), "store read/write clash")
  `OFRB_ASSERT_NEXT(a_fail_single, issue && !ok_q, s1_valid_q && s1_last_q && !s1_ok_q, "bad fail")

endmodule

[rtl/overlapping_frame_ring_buffer.sv]
// A frame read passes the command queue, the sequencer, the store read register and
// the result buffer before its first sample shows; the sequencer carries out one command
// at a time, and a frame read also stalls while the result buffer has no room.
// A two-entry command queue lets commands be accepted while a frame is still read out.
// Reset (asynchronous, active low) clears positions, fill count, queues and registers
// to their defaults; store contents stay undefined and no clearing pass is made.
module overlapping_frame_ring_buffer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ofrb_in_if.sink                        in_if,
  ofrb_out_if.source                     out_if,
  input  logic                           cfg_we_i,
  input  logic [ofrb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ofrb_pkg::CFG_W-1:0]     cfg_data_i
);
  import ofrb_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_cmd_in;
  cmd_t q_cmd_out;
  cfg_t cfg;

  // Accept and classify commands
  ofrb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd_in),
    .cfg_o       (cfg)
  );

  // Decouple front and back
  ofrb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd_out)
  );

  // Carry out store writes and frame reads
  ofrb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_cmd_i   (q_cmd_out),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .cfg_i     (cfg),
    .out_if    (out_if)
  );

endmodule

[sim/testbench.sv]
// Self-checking testbench for the overlapped frame store: random and directed commands.
`timescale 1ns / 1ps

module testbench;
  import ofrb_pkg::*;

  // Command code that the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int NUM_PHASES    = 8;
  localparam int SQUEEZE_PHASE = 3;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_GAP     = 20;
  localparam int QUIET_LIMIT   = 20000;
  localparam int REPORT_CAP    = 100;

  // Register settings per phase; -1 picks a random value
  localparam int PHASE_FRAME [NUM_PHASES] = '{1, 0, 127, 16, 64, 7, -1, 64};
  localparam int PHASE_HOP   [NUM_PHASES] = '{1, 0, 127, 5, 0, 100, -1, 32};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{30, 25, 35, 50, 35, 35, 35, 45};
  localparam int PHASE_GAP   [NUM_PHASES] = '{20, 0, 10, 25, 15, 30, 20, 0};

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [SAMPLE_W-1:0] word;
    logic [ZCOUNT_W-1:0] count;
  } command_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  ofrb_in_if  cmd_ch ();
  ofrb_out_if frame_ch ();

  overlapping_frame_ring_buffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (cmd_ch),
    .out_if      (frame_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the store and its registers
  logic [SAMPLE_W-1:0] store_words [STORE_DEPTH];
  int unsigned         write_ptr;
  int unsigned         read_ptr;
  int unsigned         held_count;
  logic [CFG_W-1:0]    frame_len_cfg;
  logic [CFG_W-1:0]    hop_cfg;

  command_t commands_to_send [$];
  res_t     frame_samples_due [$];
  command_t next_cmd;
  res_t     oldest_due;
  int       gap_pct;
  int       gap_left;
  int       hold_left;
  int       quiet_cycles = 0;
  int       mismatch_count;
  bit       squeeze_req;
  bit       squeeze_done;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound a raw frame length to one, the largest frame and the store depth
  function automatic int unsigned effective_frame(input int unsigned raw);
    int unsigned f;
    f = (raw == 0) ? 1 : raw;
    if (f > MAX_FRAME) f = MAX_FRAME;
    if (f > STORE_DEPTH) f = STORE_DEPTH;
    return f;
  endfunction

  function automatic command_t make_command(input logic [CMD_W-1:0]    cmd,
                                            input logic [SAMPLE_W-1:0] word,
                                            input logic [ZCOUNT_W-1:0] count);
    command_t c;
    c.cmd   = cmd;
    c.word  = word;
    c.count = count;
    return c;
  endfunction

  // Append a command to the pending list
  task automatic enqueue_command(input command_t c);
    commands_to_send.insert(commands_to_send.size(), c);
  endtask

  // Mostly writes and reads, some zero runs (rarely long), a few ignored codes
  function automatic command_t random_command(input int unsigned frame);
    command_t    c;
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    c.word  = $urandom();
    c.count = ZCOUNT_W'($urandom_range(0, 2 * frame));
    if (pick < 52) begin
      c.cmd = CMD_WRITE;
    end else if (pick < 66) begin
      c.cmd = CMD_ZEROS;
      if ($urandom_range(0, 19) == 0) c.count = ZCOUNT_W'($urandom_range(0, 1023));
    end else if (pick < 95) begin
      c.cmd = CMD_READ;
    end else begin
      c.cmd = CMD_UNUSED;
    end
    return c;
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] word);
    store_words[ADDR_W'(write_ptr)] = word;
    write_ptr = (write_ptr + 1) % STORE_DEPTH;
    if (held_count < STORE_DEPTH) held_count++;
  endtask

  // Update the shadow store and queue the frame samples a command must produce
  task automatic apply_command(input logic [CMD_W-1:0]    cmd,
                               input logic [SAMPLE_W-1:0] word,
                               input logic [ZCOUNT_W-1:0] count);
    int unsigned flen;
    int unsigned hop;
    res_t        due;
    case (cmd)
      CMD_WRITE: begin
        push_sample(word);
      end
      CMD_ZEROS: begin
        for (int k = 0; k < count; k++) push_sample('0);
      end
      CMD_READ: begin
        flen = effective_frame(frame_len_cfg);
        hop  = (hop_cfg == 0) ? 1 : hop_cfg;
        if (hop > flen) hop = flen;
        if (held_count < flen) begin
          // Not enough data: one failed result, state untouched
          due.sample = '0;
          due.ok     = 1'b0;
          due.last   = 1'b1;
          frame_samples_due.insert(frame_samples_due.size(), due);
        end else begin
          for (int k = 0; k < flen; k++) begin
            due.sample = store_words[ADDR_W'((read_ptr + k) % STORE_DEPTH)];
            due.ok     = 1'b1;
            due.last   = (k + 1 == flen);
            frame_samples_due.insert(frame_samples_due.size(), due);
          end
          read_ptr   = (read_ptr + hop) % STORE_DEPTH;
          held_count = held_count - hop;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatch_count < REPORT_CAP) $display("ERROR at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= CFG_W'(value);
    if (index == CFG_FRAME_LENGTH) frame_len_cfg = CFG_W'(value);
    else hop_cfg = CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every command is taken and every frame sample has come back
  task automatic wait_for_drain();
    while (commands_to_send.size() != 0 || cmd_ch.valid || frame_samples_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_GAP) @(negedge clk_i);
  endtask

  // Command driver: present queued commands, with random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ch.valid      <= 1'b0;
      cmd_ch.command    <= CMD_WRITE;
      cmd_ch.sample     <= '0;
      cmd_ch.zero_count <= '0;
      gap_left   = 0;
      write_ptr  = 0;
      read_ptr   = 0;
      held_count = 0;
      for (int k = 0; k < STORE_DEPTH; k++) store_words[ADDR_W'(k)] = '0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        apply_command(cmd_ch.command, cmd_ch.sample, cmd_ch.zero_count);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          cmd_ch.valid <= 1'b0;
        end else if (commands_to_send.size() != 0) begin
          next_cmd = commands_to_send.pop_front();
          cmd_ch.valid      <= 1'b1;
          cmd_ch.command    <= next_cmd.cmd;
          cmd_ch.sample     <= next_cmd.word;
          cmd_ch.zero_count <= next_cmd.count;
          if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 8);
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Frame monitor: check each transaction against the oldest expectation, drive ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_ch.ready <= 1'b0;
      hold_left      = 0;
      squeeze_done   = 1'b0;
      mismatch_count = 0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        if (frame_samples_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected frame sample %h", frame_ch.frame_sample));
        end else begin
          oldest_due = frame_samples_due.pop_front();
          if (frame_ch.frame_sample !== oldest_due.sample)
            flag_mismatch($sformatf("frame_sample %h, want %h",
                                    frame_ch.frame_sample, oldest_due.sample));
          if (frame_ch.frame_ok !== oldest_due.ok)
            flag_mismatch($sformatf("frame_ok %b, want %b", frame_ch.frame_ok, oldest_due.ok));
          if (frame_ch.last !== oldest_due.last)
            flag_mismatch($sformatf("last %b, want %b", frame_ch.last, oldest_due.last));
        end
      end
      if (squeeze_req && !squeeze_done) begin
        // Long hold-off so the store backs up and stalls its input
        squeeze_done = 1'b1;
        hold_left    = LONG_HOLD - 1;
        frame_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        frame_ch.ready <= 1'b0;
      end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        hold_left = $urandom_range(0, 7);
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (frame_ch.valid && frame_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int          frame_val;
    int          hop_val;
    int unsigned frame_eff;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = CFG_FRAME_LENGTH;
    cfg_data_i         = '0;
    frame_len_cfg      = FRAME_LENGTH_RST;
    hop_cfg            = HOP_LENGTH_RST;
    gap_pct            = 15;
    squeeze_req        = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed commands at the reset settings: empty read, ignored code, extreme
    // words, zero-length and full-width zero runs, store overflow, frame reads
    enqueue_command(make_command(CMD_READ, $urandom(), 10'h3FF));
    enqueue_command(make_command(CMD_UNUSED, $urandom(), 10'h155));
    enqueue_command(make_command(CMD_WRITE, 32'h0000_0000, 10'h000));
    enqueue_command(make_command(CMD_WRITE, 32'hFFFF_FFFF, 10'h3FF));
    enqueue_command(make_command(CMD_ZEROS, $urandom(), 10'd0));
    enqueue_command(make_command(CMD_READ, 32'h0, 10'h0));
    enqueue_command(make_command(CMD_ZEROS, 32'hFFFF_FFFF, 10'h3FF));
    enqueue_command(make_command(CMD_READ, $urandom(), ZCOUNT_W'($urandom())));
    enqueue_command(make_command(CMD_WRITE, 32'h8000_0001, 10'h2AA));
    enqueue_command(make_command(CMD_WRITE, 32'h7FFF_FFFE, 10'h0));
    enqueue_command(make_command(CMD_ZEROS, $urandom(), 10'd512));
    enqueue_command(make_command(CMD_READ, $urandom(), ZCOUNT_W'($urandom())));
    enqueue_command(make_command(CMD_READ, $urandom(), ZCOUNT_W'($urandom())));
    enqueue_command(make_command(CMD_UNUSED, $urandom(), 10'h3FF));
    for (int k = 0; k < 8; k++) begin
      enqueue_command(make_command(CMD_WRITE, $urandom(), ZCOUNT_W'($urandom())));
    end
    enqueue_command(make_command(CMD_READ, $urandom(), ZCOUNT_W'($urandom())));
    wait_for_drain();

    // Random phases, each under its own register settings and closed by a read
    for (int p = 0; p < NUM_PHASES; p++) begin
      frame_val = (PHASE_FRAME[p] < 0) ? $urandom_range(0, 127) : PHASE_FRAME[p];
      hop_val   = (PHASE_HOP[p] < 0) ? $urandom_range(0, 127) : PHASE_HOP[p];
      write_register(CFG_FRAME_LENGTH, frame_val);
      write_register(CFG_HOP_LENGTH, hop_val);
      @(negedge clk_i);
      frame_eff = effective_frame(frame_val);
      gap_pct   = PHASE_GAP[p];
      for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
        enqueue_command(random_command(frame_eff));
      end
      enqueue_command(make_command(CMD_READ, $urandom(), ZCOUNT_W'($urandom())));
      if (p == SQUEEZE_PHASE) squeeze_req = 1'b1;
      wait_for_drain();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ofrb_pkg.sv
rtl/ofrb_if.sv
rtl/ofrb_front.sv
rtl/ofrb_queue.sv
rtl/ofrb_back.sv
rtl/overlapping_frame_ring_buffer.sv
sim/testbench.sv
